### hw/rtl/uvs_pkg.sv
// shared constants, types and arithmetic helpers of the uv sphere strip vertex generator
// no dependencies; imported by every module of the block but uvs_delay

package uvs_pkg;

  localparam int MAX_SLICES    = 256;
  localparam int MAX_STACKS    = 256;
  localparam int FRAC_BITS_DEF = 15;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // integer quotient bit plus up to 32 fraction bits, then a rounding register
  localparam int DIV_STEPS = 33;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STACKS = 2'd2;

  typedef struct packed {
    logic        err;
    logic        ring;
    logic [17:0] vidx;
  } side_t;

  typedef struct packed {
    logic [16:0] tex_s;
    logic [16:0] tex_t;
  } tex_t;

  function automatic logic [29:0] cordic_atan(input int i);
    logic [29:0] a;
    case (i)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      24: a = 30'd41;
      25: a = 30'd20;
      26: a = 30'd10;
      27: a = 30'd5;
      28: a = 30'd3;
      29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // right shift rounding half away from zero
  function automatic logic signed [63:0] round_shr(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    logic [63:0] r;
    if (s == 0) return v;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                             input logic signed [63:0] lo,
                                             input logic signed [63:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

### hw/rtl/uvs_delay.sv
// enable-gated payload delay line used to keep side data aligned with the datapath
// depends on nothing

module uvs_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[D-1];

endmodule

### hw/rtl/uvs_frac_div.sv
// pipelined restoring divider: round(num * 2^FB / den) for num <= den, one quotient bit a stage
// depends on uvs_pkg

module uvs_frac_div import uvs_pkg::*; #(
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [8:0]    num,
  input  logic [8:0]    den,
  output logic [FB+1:0] quo
);

  logic [8:0]  rem_r [DIV_STEPS];
  logic [FB:0] q_r   [DIV_STEPS];
  logic [FB+1:0] quo_r;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_st
    logic [8:0]  rem_in;
    logic [FB:0] q_in;
    if (j == 0) begin : g_first
      assign rem_in = num;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
    end
    if (j <= FB) begin : g_bit
      logic [9:0] t;
      logic       qb;
      // first step yields the integer bit, the rest are fraction bits
      assign t  = (j == 0) ? {1'b0, rem_in} : {rem_in, 1'b0};
      assign qb = t >= {1'b0, den};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= qb ? 9'(t - {1'b0, den}) : t[8:0];
          q_r[j]   <= {q_in[FB-1:0], qb};
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= rem_in;
          q_r[j]   <= q_in;
        end
      end
    end
  end

  logic [9:0] rsum;
  logic       up;
  assign rsum = {1'b0, rem_r[DIV_STEPS-1]} + {2'b0, den[8:1]};
  assign up   = rsum >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (en) quo_r <= (FB+2)'(q_r[DIV_STEPS-1]) + (FB+2)'(up);
  end

  assign quo = quo_r;

endmodule

### hw/rtl/uvs_cordic.sv
// pipelined rotation cordic: sine and cosine of a 32-bit binary phase in Q(F)
// depends on uvs_pkg

module uvs_cordic import uvs_pkg::*; #(
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         phase,
  output logic signed [F+1:0] sin_o,
  output logic signed [F+1:0] cos_o
);

  localparam int TW = F + 2;

  logic signed [32:0] x_r [CORDIC_STEPS];
  logic signed [32:0] y_r [CORDIC_STEPS];
  logic signed [32:0] z_r [CORDIC_STEPS];
  logic [1:0]         quad_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
    logic signed [32:0] xi, yi, zi;
    logic [1:0]         qi;
    logic signed [32:0] ang;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = $signed({3'b000, phase[29:0]});
      assign qi = phase[31:30];
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign qi = quad_r[i-1];
    end
    assign ang = $signed({3'b000, cordic_atan(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        quad_r[i] <= qi;
        if (!zi[32]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ang;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ang;
        end
      end
    end
  end

  logic signed [TW-1:0] c, s;
  logic signed [TW-1:0] sin_r, cos_r;
  assign c = TW'(round_shr(64'(x_r[CORDIC_STEPS-1]), 30 - F));
  assign s = TW'(round_shr(64'(y_r[CORDIC_STEPS-1]), 30 - F));

  // rotate the first-quadrant result into the phase's quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_r[CORDIC_STEPS-1])
        2'd0: begin cos_r <= c;  sin_r <= s;  end
        2'd1: begin cos_r <= -s; sin_r <= c;  end
        2'd2: begin cos_r <= -c; sin_r <= -s; end
        default: begin cos_r <= s; sin_r <= -c; end
      endcase
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### hw/rtl/uv_sphere_strip_vertex_generator.sv
// uv sphere strip vertex generator: one column in, its upper and lower ring vertices out
// each accepted item yields its upper ring vertex and then its lower ring vertex
// a new item is taken as the lower ring job of the last one leaves; the single result port moves two vertices per item
// the whole pipeline advances together and holds while a finished vertex waits on out_stall
// reset: synchronous active-low rst_n clears valid bits and loads radius 1.0, 16 slices, 16 stacks
// depends on uvs_pkg, uvs_frac_div, uvs_cordic, uvs_delay

module uv_sphere_strip_vertex_generator import uvs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // column input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_stack_index,
  input  logic [8:0]           in_slice_index,
  // vertex output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [16:0]   out_pos_x,
  output logic signed [16:0]   out_pos_y,
  output logic signed [16:0]   out_pos_z,
  output logic signed [15:0]   out_norm_x,
  output logic signed [15:0]   out_norm_y,
  output logic signed [15:0]   out_norm_z,
  output logic [16:0]          out_tex_s,
  output logic [16:0]          out_tex_t,
  output logic [17:0]          out_vertex_index,
  output logic                 out_lower_ring,
  output logic                 out_last,
  output logic                 out_index_error
);

  localparam int TW     = FRAC_BITS + 2;        // trig and normal width, Q(F) with sign
  localparam int PW     = TW + 17;              // normal times radius
  localparam int POST   = 3;                    // product, normal and position stages
  localparam int TEX_D  = CORDIC_LAT + POST;
  localparam int SIDE_D = DIV_LAT + CORDIC_LAT + POST;
  localparam int VLAT   = SIDE_D + 1;
  localparam int Q_RSH  = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
  localparam int Q_LSH  = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;

  // ---------------------------------------------------------------- config registers
  logic [15:0] radius_r;
  logic [8:0]  slice_count_r, stack_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= 16'd256;
      slice_count_r <= 9'd16;
      stack_count_r <= 9'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIUS: radius_r      <= cfg_data;
        CFG_SLICES: slice_count_r <= cfg_data[8:0];
        CFG_STACKS: stack_count_r <= cfg_data[8:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- pipeline advance
  // every stage moves together; only a vertex stuck at the output holds it
  logic en;
  logic out_valid_r;
  assign en = !(out_valid_r && out_stall);

  // ---------------------------------------------------------------- item hold and ring split
  // an item sits here until it has emitted the upper then the lower ring job
  logic       busy_r, ring_r;
  logic [7:0] hold_stk_r;
  logic [8:0] hold_slc_r;
  logic       in_xfer;

  // a new transfer lands in the same cycle the lower ring job leaves
  assign in_stall = busy_r && !(ring_r && en);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ring_r <= 1'b0;
    end else begin
      if (busy_r && en) begin
        if (!ring_r) begin
          ring_r <= 1'b1;
        end else begin
          ring_r <= 1'b0;
          busy_r <= 1'b0;
        end
      end
      if (in_xfer) begin
        busy_r <= 1'b1;
        ring_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_stk_r <= in_stack_index;
      hold_slc_r <= in_slice_index;
    end
  end

  // ---------------------------------------------------------------- stage 0: ring job setup
  logic        err_c;
  logic [8:0]  k_c;
  logic [17:0] vidx_c;
  logic [8:0]  s0_k_r, s0_tsa_r, s0_slc_r;
  side_t       s0_side_r;

  always_comb begin
    // bad counts are reported like an out-of-range index
    err_c = (slice_count_r == 9'd0) || (32'(slice_count_r) > 32'(MAX_SLICES)) ||
            (stack_count_r == 9'd0) || (32'(stack_count_r) > 32'(MAX_STACKS)) ||
            ({1'b0, hold_stk_r} >= stack_count_r) || (hold_slc_r > slice_count_r);
    k_c    = {1'b0, hold_stk_r} + {8'd0, ring_r};
    vidx_c = 18'(({10'd0, hold_stk_r} * ({9'd0, slice_count_r} + 18'd1) << 1) +
                 ({9'd0, hold_slc_r} << 1) + {17'd0, ring_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_k_r         <= k_c;
      s0_tsa_r       <= stack_count_r - k_c;
      s0_slc_r       <= hold_slc_r;
      s0_side_r.err  <= err_c;
      s0_side_r.ring <= ring_r;
      s0_side_r.vidx <= vidx_c;
    end
  end

  // valid bits travel beside the datapath, stage 0 through the position stage
  logic [VLAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLAT-2:0], busy_r};
    end
  end

  // ---------------------------------------------------------------- ratio dividers
  logic [32:0] col_q;
  logic [33:0] lon_q;
  logic [17:0] ts_q, tt_q;

  uvs_frac_div #(.FB(31)) u_div_col (
    .clk(clk), .en(en), .num(s0_k_r), .den(stack_count_r), .quo(col_q)
  );
  uvs_frac_div #(.FB(32)) u_div_lon (
    .clk(clk), .en(en), .num(s0_slc_r), .den(slice_count_r), .quo(lon_q)
  );
  uvs_frac_div #(.FB(16)) u_div_ts (
    .clk(clk), .en(en), .num(s0_slc_r), .den(slice_count_r), .quo(ts_q)
  );
  uvs_frac_div #(.FB(16)) u_div_tt (
    .clk(clk), .en(en), .num(s0_tsa_r), .den(stack_count_r), .quo(tt_q)
  );

  // ---------------------------------------------------------------- sine and cosine
  // longitude phase wraps modulo a full turn, so the last slice lands on zero
  logic signed [TW-1:0] sc, cc, sl, cl;

  uvs_cordic #(.F(FRAC_BITS)) u_cordic_col (
    .clk(clk), .en(en), .phase(col_q[31:0]), .sin_o(sc), .cos_o(cc)
  );
  uvs_cordic #(.F(FRAC_BITS)) u_cordic_lon (
    .clk(clk), .en(en), .phase(lon_q[31:0]), .sin_o(sl), .cos_o(cl)
  );

  // ---------------------------------------------------------------- side data alignment
  tex_t  tex_in, tex_d;
  side_t side_d;

  assign tex_in.tex_s = ts_q[16:0];
  assign tex_in.tex_t = tt_q[16:0];

  uvs_delay #(.W($bits(tex_t)), .D(TEX_D)) u_dly_tex (
    .clk(clk), .en(en), .din(tex_in), .dout(tex_d)
  );
  uvs_delay #(.W($bits(side_t)), .D(SIDE_D)) u_dly_side (
    .clk(clk), .en(en), .din(s0_side_r), .dout(side_d)
  );

  // ---------------------------------------------------------------- normal and position math
  logic signed [2*TW-1:0] m1_px_r, m1_py_r;
  logic signed [TW-1:0]   m1_cc_r;
  logic signed [TW-1:0]   n_r  [3];
  logic signed [PW-1:0]   p_r  [3];
  logic signed [15:0]     q15_r [3];
  logic signed [16:0]     radius_s;

  assign radius_s = $signed({1'b0, radius_r});

  always_ff @(posedge clk) begin
    if (en) begin
      // sin lon * sin col and cos lon * sin col
      m1_px_r <= sl * sc;
      m1_py_r <= cl * sc;
      m1_cc_r <= cc;
      // back to Q(F); half-away rounding is symmetric so negate after
      n_r[0] <= TW'(-round_shr(64'(m1_px_r), FRAC_BITS));
      n_r[1] <= TW'(round_shr(64'(m1_py_r), FRAC_BITS));
      n_r[2] <= m1_cc_r;
      for (int j = 0; j < 3; j++) begin
        p_r[j]   <= n_r[j] * radius_s;
        q15_r[j] <= 16'(sat(round_shr(64'(n_r[j]), Q_RSH) <<< Q_LSH,
                            -64'sd32768, 64'sd32767));
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic signed [16:0] pos_r  [3];
  logic signed [15:0] norm_r [3];
  logic [16:0]        tex_s_r, tex_t_r;
  logic [17:0]        vidx_r;
  logic               ring_o_r, err_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[VLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // an out-of-range column zeroes everything but the ring flags and the error flag
      for (int j = 0; j < 3; j++) begin
        pos_r[j]  <= side_d.err ? 17'sd0 :
                     17'(sat(round_shr(64'(p_r[j]), FRAC_BITS), -64'sd65535, 64'sd65535));
        norm_r[j] <= side_d.err ? 16'sd0 : q15_r[j];
      end
      tex_s_r  <= side_d.err ? 17'd0 : tex_d.tex_s;
      tex_t_r  <= side_d.err ? 17'd0 : tex_d.tex_t;
      vidx_r   <= side_d.err ? 18'd0 : side_d.vidx;
      ring_o_r <= side_d.ring;
      err_o_r  <= side_d.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = pos_r[0];
  assign out_pos_y        = pos_r[1];
  assign out_pos_z        = pos_r[2];
  assign out_norm_x       = norm_r[0];
  assign out_norm_y       = norm_r[1];
  assign out_norm_z       = norm_r[2];
  assign out_tex_s        = tex_s_r;
  assign out_tex_t        = tex_t_r;
  assign out_vertex_index = vidx_r;
  assign out_lower_ring   = ring_o_r;
  assign out_last         = ring_o_r;
  assign out_index_error  = err_o_r;

endmodule
